// ----- src/pif_pkg.sv -----
package pif_pkg;

  // Conversion codes
  localparam logic [2:0] FUNC_SDEC   = 3'd0;
  localparam logic [2:0] FUNC_UDEC   = 3'd1;
  localparam logic [2:0] FUNC_OCT    = 3'd2;
  localparam logic [2:0] FUNC_HEXLO  = 3'd3;
  localparam logic [2:0] FUNC_HEXUP  = 3'd4;
  localparam logic [2:0] FUNC_PTR    = 3'd5;

  // Length codes
  localparam logic [1:0] LEN_INT   = 2'd0;
  localparam logic [1:0] LEN_SHORT = 2'd1;
  localparam logic [1:0] LEN_LONG  = 2'd2;

  localparam int MAX_WIDTH     = 64;
  localparam int MAX_PRECISION = 60;

  // Enough digit slots for 64 bits in octal (22), decimal needs 20
  localparam int NUM_DIGITS = 22;
  localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
  localparam int CONV_STEPS = 64;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = CH_ZERO + {4'd0, d};
    end else if (upper) begin
      r = CH_UP_A + {4'd0, d} - 8'd10;
    end else begin
      r = CH_LOW_A + {4'd0, d} - 8'd10;
    end
    return r;
  endfunction

endpackage

// ----- src/printf_integer_formatter.sv -----
// printf-style integer conversion (%d %u %o %x %X %p) to a serial ASCII stream.
//
// Input channel: in_valid / in_stall with one conversion request per
// transaction (func, value, length, flags, field width, precision).
// Output channel: out_valid / out_stall, one character per transaction, most
// significant first, last set on the final character. A request that yields
// no characters (bad func code, or zero value with precision zero and no
// sign, prefix or padding) produces no output transaction at all.
//
// A decimal request passes through the shift-and-add-3 binary to BCD
// unit; octal and hex digits load directly. A leading-digit scan then walks
// down to the top nonzero digit, the bookkeeping states S_CALC1, S_CALC2
// and S_CALC3 follow, then one character leaves per cycle (up to 64) while
// the receiver does not stall. The next request is taken only after the
// final character has been registered for output, or after an empty
// conversion is dropped; in_stall stays high until then.
// The output register lets the next request enter while the final character
// still waits. When the receiver stalls, hold the character and the
// emission counter until it is taken.
// Reset clears the sequencer and the output valid; payload registers are
// left as they are.
module printf_integer_formatter (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] func,
  input  logic [63:0] value,
  input  logic [1:0] length_mode,
  input  logic       left_justify,
  input  logic       force_plus,
  input  logic       space_sign,
  input  logic       zero_fill,
  input  logic       alt_form,
  input  logic [6:0] field_width,
  input  logic       precision_given,
  input  logic [5:0] precision,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] ch,
  output logic       last
);
  import pif_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_CALC1 = 3'd3;
  localparam logic [2:0] S_CALC2 = 3'd4;
  localparam logic [2:0] S_CALC3 = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state;

  // Request fields held for the whole conversion
  logic       is_ptr, upper, left, zfill, alt, prec_set, mag_zero, suppress;
  logic       is_oct, is_hex, has_sign;
  logic [7:0] sign_ch;
  logic [5:0] prec;
  logic [6:0] width;

  // Shared conversion unit
  logic [63:0] bin;
  digits_t     dig;
  logic [5:0]  cnt;
  logic [DIG_IDX_W-1:0] msd;

  // Layout bookkeeping
  logic [4:0] ndig;
  logic [5:0] need;
  logic [1:0] npre;
  logic [6:0] core, zpad;
  logic [6:0] b0, b1, b2, b3, b4, nt, pos;

  assign in_stall = (state != S_IDLE);

  // ---------------------------------------------------------------
  // Accept-time argument handling: extend per length, take magnitude
  // ---------------------------------------------------------------
  logic [63:0] ext_v, mag_c;
  logic        neg_c;
  always_comb begin
    case (length_mode)
      LEN_SHORT: ext_v = (func == FUNC_SDEC) ? {{48{value[15]}}, value[15:0]}
                                             : {48'd0, value[15:0]};
      LEN_INT:   ext_v = (func == FUNC_SDEC) ? {{32{value[31]}}, value[31:0]}
                                             : {32'd0, value[31:0]};
      default:   ext_v = value;
    endcase
    if (func == FUNC_PTR) ext_v = value;
    neg_c = (func == FUNC_SDEC) && ext_v[63];
    mag_c = neg_c ? (~ext_v + 64'd1) : ext_v;
  end

  // Direct digit load for octal and hex; slots above the value read as zero
  digits_t                  load_dig;
  logic [4*NUM_DIGITS-1:0]  magx;
  always_comb begin
    magx = {{(4*NUM_DIGITS-64){1'b0}}, mag_c};
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (func == FUNC_OCT) begin
        load_dig[i] = {1'b0, magx[3*i +: 3]};
      end else begin
        load_dig[i] = magx[4*i +: 4];
      end
    end
  end

  // One shift-and-add-3 step of the binary to BCD unit
  digits_t adj, dab_next;
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (dig[i] >= 4'd5) ? dig[i] + 4'd3 : dig[i];
    end
    for (int i = 0; i < NUM_DIGITS; i++) begin
      dab_next[i] = {adj[i][2:0], (i == 0) ? bin[63] : adj[(i == 0) ? 0 : i-1][3]};
    end
  end

  // ---------------------------------------------------------------
  // Layout arithmetic
  // ---------------------------------------------------------------
  logic [4:0] ndig_c;
  logic [5:0] need_c;
  logic [1:0] npre_c;
  logic [6:0] core_c, zpad_c, core2_c, pad_c, lead_c;
  always_comb begin
    ndig_c = suppress ? 5'd0 : 5'({1'b0, msd} + 6'd1);
    need_c = (prec_set && (prec > {1'b0, ndig_c})) ? prec - {1'b0, ndig_c} : 6'd0;
    npre_c = 2'd0;
    if (is_ptr) begin
      npre_c = 2'd2;
    end else if (alt && is_hex && !mag_zero) begin
      npre_c = 2'd2;
    end else if (alt && is_oct && (need_c == 6'd0) && !((ndig_c != 5'd0) && mag_zero)) begin
      npre_c = 2'd1;
    end
    core_c = {2'b00, ndig} + {1'b0, need} + {5'd0, npre} + {6'd0, has_sign};
    zpad_c = (!prec_set && zfill && !left && (width > core_c)) ? width - core_c : 7'd0;
    core2_c = core + zpad;
    pad_c   = (width > core2_c) ? width - core2_c : 7'd0;
    lead_c  = left ? 7'd0 : pad_c;
  end

  // ---------------------------------------------------------------
  // Character selection for the current emission position
  // ---------------------------------------------------------------
  logic [6:0] didx, pidx;
  logic [7:0] char_c;
  logic       last_c, adv;
  always_comb begin
    didx = b4 - 7'd1 - pos;
    pidx = pos - b1;
    if (pos < b0) begin
      char_c = CH_SPACE;
    end else if (pos < b1) begin
      char_c = sign_ch;
    end else if (pos < b2) begin
      if (pidx == 7'd0) char_c = CH_ZERO;
      else              char_c = upper ? CH_UP_X : CH_LOW_X;
    end else if (pos < b3) begin
      char_c = CH_ZERO;
    end else if (pos < b4) begin
      char_c = digit_char(dig[didx[DIG_IDX_W-1:0]], upper);
    end else begin
      char_c = CH_SPACE;
    end
    last_c = (pos == nt - 7'd1);
    adv    = !out_valid || !out_stall;
  end

  // ---------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_EMIT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && func <= FUNC_PTR) begin
            is_ptr   <= (func == FUNC_PTR);
            upper    <= (func == FUNC_HEXUP);
            is_oct   <= (func == FUNC_OCT);
            is_hex   <= (func == FUNC_HEXLO) || (func == FUNC_HEXUP);
            left     <= left_justify;
            zfill    <= zero_fill;
            alt      <= alt_form;
            prec_set <= precision_given;
            prec     <= (precision > 6'(MAX_PRECISION)) ? 6'(MAX_PRECISION) : precision;
            width    <= (field_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : field_width;
            mag_zero <= (mag_c == 64'd0);
            suppress <= (func != FUNC_PTR) && precision_given && (precision == 6'd0)
                        && (mag_c == 64'd0);
            has_sign <= neg_c || ((func == FUNC_SDEC) && (force_plus || space_sign));
            sign_ch  <= neg_c ? CH_MINUS : (force_plus ? CH_PLUS : CH_SPACE);
            msd      <= DIG_IDX_W'(NUM_DIGITS - 1);
            cnt      <= 6'd0;
            bin      <= mag_c;
            if (func == FUNC_SDEC || func == FUNC_UDEC) begin
              dig   <= '0;
              state <= S_CONV;
            end else begin
              dig   <= load_dig;
              state <= S_SCAN;
            end
          end
        end
        S_CONV: begin
          dig <= dab_next;
          bin <= {bin[62:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'(CONV_STEPS - 1)) state <= S_SCAN;
        end
        S_SCAN: begin
          // Walk down from the top slot to the leading nonzero digit
          if (dig[msd] != 4'd0 || msd == '0) begin
            state <= S_CALC1;
          end else begin
            msd <= msd - DIG_IDX_W'(1);
          end
        end
        S_CALC1: begin
          ndig  <= ndig_c;
          need  <= need_c;
          npre  <= npre_c;
          state <= S_CALC2;
        end
        S_CALC2: begin
          core  <= core_c;
          zpad  <= zpad_c;
          state <= S_CALC3;
        end
        S_CALC3: begin
          b0  <= lead_c;
          b1  <= lead_c + {6'd0, has_sign};
          b2  <= lead_c + {6'd0, has_sign} + {5'd0, npre};
          b3  <= lead_c + {6'd0, has_sign} + {5'd0, npre} + zpad + {1'b0, need};
          b4  <= lead_c + {6'd0, has_sign} + {5'd0, npre} + zpad + {1'b0, need}
                 + {2'b00, ndig};
          nt  <= core2_c + pad_c;
          pos <= 7'd0;
          // Drop empty conversions without any output transaction
          state <= ((core2_c + pad_c) == 7'd0) ? S_IDLE : S_EMIT;
        end
        S_EMIT: begin
          if (adv) begin
            out_valid <= 1'b1;
            ch        <= char_c;
            last      <= last_c;
            pos       <= pos + 7'd1;
            if (last_c) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (pos < nt))
    else $error("emission position ran past the character count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (nt <= 7'(MAX_WIDTH)))
    else $error("character count exceeds the output limit");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (msd < DIG_IDX_W'(NUM_DIGITS)))
    else $error("leading digit scan left the digit slots");

  a_calc_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC1) |-> ($past(state) == S_SCAN))
    else $error("layout step entered without a finished digit scan");

endmodule

// ----- verif/printf_integer_formatter_tb.sv -----
`timescale 1ns / 100ps

module printf_integer_formatter_tb;
  import pif_pkg::*;

  // Length code 3 is not named in the package; the block treats it as long.
  localparam logic [1:0] LEN_ALIAS_LONG = 2'd3;

  // Run limits and pressure knobs
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 300;
  localparam int MAX_CHARS       = 64;
  localparam int REPORT_LIMIT    = 10;

  // One conversion request, field for field as on the input ports
  typedef struct {
    logic [2:0]  func;
    logic [63:0] value;
    logic [1:0]  length_mode;
    logic        left_justify;
    logic        force_plus;
    logic        space_sign;
    logic        zero_fill;
    logic        alt_form;
    logic [6:0]  field_width;
    logic        precision_given;
    logic [5:0]  precision;
  } conv_req_t;

  // One output character transaction
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  // Clock, reset and DUT ports; every input starts at a known value
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  func = FUNC_SDEC;
  logic [63:0] value = '0;
  logic [1:0]  length_mode = LEN_INT;
  logic        left_justify = 1'b0;
  logic        force_plus = 1'b0;
  logic        space_sign = 1'b0;
  logic        zero_fill = 1'b0;
  logic        alt_form = 1'b0;
  logic [6:0]  field_width = '0;
  logic        precision_given = 1'b0;
  logic [5:0]  precision = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  ch;
  logic        last;

  // Characters predicted for accepted requests, oldest first
  char_beat_t pending_chars[$];

  int mismatch_count = 0;
  int cycle_count    = 0;

  // Idle rates in percent for the sender and the receiver
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;

  // Receiver hold-off: bump hold_off_req to start one long stall stretch
  int hold_off_req  = 0;
  int hold_off_seen = 0;
  int hold_off_left = 0;

  printf_integer_formatter u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .func            (func),
    .value           (value),
    .length_mode     (length_mode),
    .left_justify    (left_justify),
    .force_plus      (force_plus),
    .space_sign      (space_sign),
    .zero_fill       (zero_fill),
    .alt_form        (alt_form),
    .field_width     (field_width),
    .precision_given (precision_given),
    .precision       (precision),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .ch              (ch),
    .last            (last)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Abort a hung run; the limit is several times the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: run a requested hold-off to its end, else stall at random
  always @(posedge clk) begin
    if (hold_off_req != hold_off_seen) begin
      hold_off_seen <= hold_off_req;
      hold_off_left <= HOLD_OFF_CYCLES;
      out_stall     <= 1'b1;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
      out_stall     <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Build the expected text of one request and queue it character by
  // character: [left spaces][sign][prefix][zeros][digits][right spaces].
  function automatic void format_conversion(input conv_req_t r);
    int          width_sat, prec_sat, base, need, zpad, core, pad, n;
    logic [63:0] wide, mag, rest;
    logic [3:0]  d;
    logic [7:0]  sign_ch;
    logic [7:0]  rev_digits[$];
    logic [7:0]  prefix[$];
    logic [7:0]  text[$];
    bit          is_ptr;
    char_beat_t  beat;
    // Unused func codes produce nothing at all
    if (r.func > FUNC_PTR) return;
    is_ptr    = (r.func == FUNC_PTR);
    width_sat = (r.field_width > MAX_WIDTH) ? MAX_WIDTH : int'(r.field_width);
    prec_sat  = (r.precision > MAX_PRECISION) ? MAX_PRECISION : int'(r.precision);
    base      = (r.func <= FUNC_UDEC) ? 10 : ((r.func == FUNC_OCT) ? 8 : 16);
    sign_ch   = 8'h00;

    // Sign-extend for signed decimal, zero-extend otherwise; pointer is 64 bits
    if (r.func == FUNC_SDEC) begin
      case (r.length_mode)
        LEN_SHORT: wide = {{48{r.value[15]}}, r.value[15:0]};
        LEN_INT:   wide = {{32{r.value[31]}}, r.value[31:0]};
        default:   wide = r.value;
      endcase
      if (wide[63]) begin
        sign_ch = CH_MINUS;
        mag     = ~wide + 64'd1;
      end else begin
        mag = wide;
        if (r.force_plus) sign_ch = CH_PLUS;
        else if (r.space_sign) sign_ch = CH_SPACE;
      end
    end else if (is_ptr) begin
      mag = r.value;
    end else begin
      case (r.length_mode)
        LEN_SHORT: mag = {48'd0, r.value[15:0]};
        LEN_INT:   mag = {32'd0, r.value[31:0]};
        default:   mag = r.value;
      endcase
    end

    // Zero with an explicit zero precision has no digits, except for pointer
    if (is_ptr || !r.precision_given || prec_sat != 0 || mag != 64'd0) begin
      rest = mag;
      do begin
        d = 4'(rest % base);
        if (d < 4'd10) rev_digits.push_back(CH_ZERO + 8'(d));
        else if (r.func == FUNC_HEXUP) rev_digits.push_back(CH_UP_A + 8'(d) - 8'd10);
        else rev_digits.push_back(CH_LOW_A + 8'(d) - 8'd10);
        rest = rest / base;
      end while (rest != 64'd0);
    end

    need = (r.precision_given && prec_sat > rev_digits.size()) ?
           prec_sat - rev_digits.size() : 0;

    // Prefix: always 0x for pointer; with alt form, 0x/0X for nonzero hex and a
    // lone 0 for octal unless precision adds zeros or the digits start with one
    if (is_ptr) begin
      prefix.push_back(CH_ZERO);
      prefix.push_back(CH_LOW_X);
    end else if (r.alt_form) begin
      if ((r.func == FUNC_HEXLO || r.func == FUNC_HEXUP) && mag != 64'd0) begin
        prefix.push_back(CH_ZERO);
        prefix.push_back((r.func == FUNC_HEXUP) ? CH_UP_X : CH_LOW_X);
      end else if (r.func == FUNC_OCT) begin
        if (need == 0 && !(rev_digits.size() > 0 && rev_digits[$] == CH_ZERO))
          prefix.push_back(CH_ZERO);
      end
    end

    // Zero fill only without precision and without left justify
    core = rev_digits.size() + need + prefix.size() + ((sign_ch != 8'h00) ? 1 : 0);
    zpad = (!r.precision_given && r.zero_fill && !r.left_justify && width_sat > core) ?
           width_sat - core : 0;
    core = core + zpad;
    pad  = (width_sat > core) ? width_sat - core : 0;

    if (!r.left_justify) repeat (pad) text.push_back(CH_SPACE);
    if (sign_ch != 8'h00) text.push_back(sign_ch);
    foreach (prefix[i]) text.push_back(prefix[i]);
    repeat (zpad + need) text.push_back(CH_ZERO);
    for (int i = rev_digits.size() - 1; i >= 0; i--) text.push_back(rev_digits[i]);
    if (r.left_justify) repeat (pad) text.push_back(CH_SPACE);

    n = (text.size() > MAX_CHARS) ? MAX_CHARS : text.size();
    for (int k = 0; k < n; k++) begin
      beat.ch   = text[k];
      beat.last = (k == n - 1);
      pending_chars.push_back(beat);
    end
  endfunction

  function automatic conv_req_t make_request(
    input logic [2:0] f, input logic [63:0] v, input logic [1:0] lm,
    input int lj, input int fp, input int sp, input int zf, input int af,
    input int w, input int pg, input int p);
    conv_req_t r;
    r.func = f;                   r.value = v;               r.length_mode = lm;
    r.left_justify = 1'(lj);      r.force_plus = 1'(fp);     r.space_sign = 1'(sp);
    r.zero_fill = 1'(zf);         r.alt_form = 1'(af);       r.field_width = 7'(w);
    r.precision_given = 1'(pg);   r.precision = 6'(p);
    return r;
  endfunction

  // Mostly well-formed requests with random content; a few unused func
  // codes, length code 3 and oversized width or precision as noise.
  function automatic conv_req_t random_request();
    conv_req_t r;
    int        pick;
    if ($urandom_range(99) < 4) r.func = FUNC_PTR + 3'($urandom_range(2, 1));
    else r.func = 3'($urandom_range(5, 0));
    pick = $urandom_range(9);
    case (pick)
      0:       r.value = '0;
      1:       r.value = '1;
      2:       r.value = 64'($urandom_range(20));
      3:       r.value = {$urandom, $urandom} >> $urandom_range(63);
      4:       r.value = 64'd1 << $urandom_range(63);
      5:       r.value = ~(64'd1 << $urandom_range(63));
      default: r.value = {$urandom, $urandom};
    endcase
    if ($urandom_range(19) == 0) r.length_mode = LEN_ALIAS_LONG;
    else r.length_mode = 2'($urandom_range(2));
    r.left_justify = 1'($urandom_range(1));
    r.force_plus   = 1'($urandom_range(1));
    r.space_sign   = 1'($urandom_range(1));
    r.zero_fill    = 1'($urandom_range(1));
    r.alt_form     = 1'($urandom_range(1));
    pick = $urandom_range(9);
    if (pick < 3) r.field_width = '0;
    else if (pick == 9) r.field_width = 7'($urandom_range(127));
    else r.field_width = 7'($urandom_range(20));
    r.precision_given = ($urandom_range(9) < 4);
    if ($urandom_range(9) == 0) r.precision = 6'($urandom_range(63));
    else r.precision = 6'($urandom_range(12));
    return r;
  endfunction

  // Offer one request, idling first at the sender rate; predict its
  // characters at the edge where the transaction is accepted.
  task automatic send_request(input conv_req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    func            <= r.func;
    value           <= r.value;
    length_mode     <= r.length_mode;
    left_justify    <= r.left_justify;
    force_plus      <= r.force_plus;
    space_sign      <= r.space_sign;
    zero_fill       <= r.zero_fill;
    alt_form        <= r.alt_form;
    field_width     <= r.field_width;
    precision_given <= r.precision_given;
    precision       <= r.precision;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    format_conversion(r);
  endtask

  task automatic wait_for_drain();
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input char_beat_t want);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("mismatch (%s): want ch=%h last=%b, got ch=%h last=%b at cycle %0d",
               what, want.ch, want.last, ch, last, cycle_count);
  endtask

  // Compare every accepted character with the oldest prediction
  always @(posedge clk) begin : check_output
    char_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        want.ch   = 8'h00;
        want.last = 1'b0;
        note_mismatch("unexpected character", want);
      end else begin
        want = pending_chars.pop_front();
        if (want.ch !== ch || want.last !== last) note_mismatch("character", want);
      end
    end
  end

  // Extremes of each field, every conversion and each special case
  task automatic test_directed_cases();
    // plain zero, minus one, int and long minimum
    send_request(make_request(FUNC_SDEC, 64'd0, LEN_INT, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(FUNC_SDEC, '1, LEN_INT, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(FUNC_SDEC, 64'h0000_0000_8000_0000, LEN_INT,
                              0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(FUNC_SDEC, 64'h8000_0000_0000_0000, LEN_LONG,
                              0, 0, 0, 0, 0, 0, 0, 0));
    // short extremes with plus and space signs
    send_request(make_request(FUNC_SDEC, 64'hFFFF_FFFF_FFFF_7FFF, LEN_SHORT,
                              0, 1, 0, 0, 0, 10, 0, 0));
    send_request(make_request(FUNC_SDEC, 64'h8000, LEN_SHORT, 0, 0, 1, 0, 0, 0, 0, 0));
    send_request(make_request(FUNC_SDEC, 64'd42, LEN_INT, 0, 0, 1, 0, 0, 0, 0, 0));
    // zero fill, and zero fill cancelled by left justify or by precision
    send_request(make_request(FUNC_SDEC, 64'd42, LEN_INT, 0, 1, 0, 1, 0, 8, 0, 0));
    send_request(make_request(FUNC_SDEC, 64'd42, LEN_INT, 1, 0, 0, 1, 0, 8, 0, 0));
    send_request(make_request(FUNC_SDEC, 64'd42, LEN_INT, 0, 0, 0, 1, 0, 8, 1, 5));
    // unsigned extremes; sign flags must be ignored
    send_request(make_request(FUNC_UDEC, '1, LEN_LONG, 0, 1, 1, 0, 0, 0, 0, 0));
    send_request(make_request(FUNC_UDEC, '1, LEN_ALIAS_LONG, 0, 0, 0, 0, 0, 0, 0, 0));
    // octal leading zero: added, already present, covered by precision
    send_request(make_request(FUNC_OCT, 64'd8, LEN_INT, 0, 0, 0, 0, 1, 0, 0, 0));
    send_request(make_request(FUNC_OCT, 64'd0, LEN_INT, 0, 0, 0, 0, 1, 0, 0, 0));
    send_request(make_request(FUNC_OCT, 64'd8, LEN_INT, 0, 0, 0, 0, 1, 0, 1, 5));
    send_request(make_request(FUNC_OCT, 64'd0, LEN_INT, 0, 0, 0, 0, 1, 0, 1, 0));
    // hex prefix with zero fill, upper case, and no prefix on zero
    send_request(make_request(FUNC_HEXLO, 64'hDEAD_BEEF, LEN_INT, 0, 0, 0, 1, 1, 14, 0, 0));
    send_request(make_request(FUNC_HEXUP, '1, LEN_LONG, 0, 0, 0, 0, 1, 0, 0, 0));
    send_request(make_request(FUNC_HEXLO, 64'd0, LEN_SHORT, 0, 0, 0, 0, 1, 0, 0, 0));
    // zero with zero precision: empty, spaces only, pointer still shows 0x0
    send_request(make_request(FUNC_SDEC, 64'd0, LEN_INT, 0, 0, 0, 0, 0, 0, 1, 0));
    send_request(make_request(FUNC_SDEC, 64'd0, LEN_INT, 0, 0, 0, 0, 0, 3, 1, 0));
    send_request(make_request(FUNC_PTR, 64'd0, LEN_INT, 0, 1, 1, 0, 1, 0, 1, 0));
    send_request(make_request(FUNC_PTR, 64'h1234, LEN_SHORT, 1, 0, 0, 0, 0, 20, 1, 8));
    send_request(make_request(FUNC_PTR, '1, LEN_INT, 0, 1, 0, 1, 1, 0, 0, 0));
    // width and precision beyond their limits saturate
    send_request(make_request(FUNC_UDEC, 64'd7, LEN_INT, 0, 0, 0, 0, 0, 127, 0, 0));
    send_request(make_request(FUNC_SDEC, -64'sd5, LEN_LONG, 0, 0, 0, 0, 0, 64, 1, 63));
    // unused func codes are dropped without output
    send_request(make_request(FUNC_PTR + 3'd1, 64'd1, LEN_INT, 0, 0, 0, 0, 0, 5, 0, 0));
    send_request(make_request(FUNC_PTR + 3'd2, '1, LEN_LONG, 1, 1, 1, 1, 1, 127, 1, 63));
  endtask

  // Count only requests that the block actually converts
  task automatic test_random_conversions(input int count);
    conv_req_t r;
    int        converted;
    converted = 0;
    while (converted < count) begin
      r = random_request();
      send_request(r);
      if (r.func <= FUNC_PTR) converted++;
    end
  endtask

  // Hold the receiver off for a long stretch while requests keep coming,
  // so the output backs up and the block stalls its input.
  task automatic test_output_hold_off();
    tx_idle_pct = 0;
    hold_off_req <= hold_off_req + 1;
    repeat (6) send_request(random_request());
  endtask

  // Pause the sender until every predicted character has arrived
  task automatic test_drain_pause();
    in_valid <= 1'b0;
    wait_for_drain();
    repeat (4) send_request(random_request());
  endtask

  initial begin
    // Hold reset, release it, and let the block idle before the first request
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 33;
    rx_stall_pct <= 56;
    test_directed_cases();
    test_random_conversions(95);

    tx_idle_pct = 56;
    rx_stall_pct <= 33;
    test_random_conversions(95);
    test_output_hold_off();

    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    test_drain_pause();
    test_random_conversions(95);

    // Drop valid, drain, then watch for stray characters a while longer
    in_valid <= 1'b0;
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
